/* design/radial_wave_damping_zone_defines.svh */
// Assertion macros for the radial wave damping zone.
// Depends on nothing; included by the top level, which carries the assertions.
`ifndef RADIAL_WAVE_DAMPING_ZONE_DEFINES_SVH
`define RADIAL_WAVE_DAMPING_ZONE_DEFINES_SVH

// A condition that must hold in the same cycle as its trigger.
`define RWDZ_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("rwdz: check failed");

// A condition that must hold after its trigger, delayed by n.
`define RWDZ_ASSERT_DELAY(label, clk, rst, cond, n, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##(n) (expr)) \
    else $error("rwdz: expected result did not appear");

`endif

/* design/rwdz_pkg.sv */
// Shared widths, register codes, payload types and saturation for the damping zone.
// Depends on nothing; used by every module of the block.
`default_nettype none

package rwdz_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int RADIUS_W    = 31;
  localparam int FRAC_W      = 17;
  localparam int STEP_W      = 31;
  localparam int CFG_IDX_W   = 3;
  localparam int DIFF_W      = VALUE_WIDTH + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_Y_MIN            = 3'd0,
    REG_Y_MAX            = 3'd1,
    REG_INNER_FRACTION   = 3'd2,
    REG_OUTER_FRACTION   = 3'd3,
    REG_TIME_STEP        = 3'd4,
    REG_FRAME_RATE_SHIFT = 3'd5
  } cfg_reg_t;

  // Zone geometry: positions and distances in signed Q16.16 with headroom.
  localparam int SPAN_W  = VALUE_WIDTH + 1;
  localparam int OFS_P_W = SPAN_W + FRAC_W + 1;
  localparam int POS_W   = 38;
  localparam int CAP_W   = POS_W + 9;

  // Ramp divider: 24 quotient bits, capped at 128.0.
  localparam int RAMP_W     = 24;
  localparam int RAMP_STEPS = RAMP_W;
  localparam int RDIV_W     = POS_W + RAMP_W;
  localparam int RAMP_LAT   = RAMP_STEPS + 2;

  // Square root of radius * 2^16.
  localparam int ROOT_W   = 24;
  localparam int SQ_IN_W  = 2 * ROOT_W;
  localparam int SQ_REM_W = ROOT_W + 4;
  localparam int ROOT_LAT = ROOT_W + 2;

  localparam int RAMP2_W   = 31;
  localparam int TAU1_W    = RADIUS_W + ROOT_W - 16;
  localparam int TAU_W     = TAU1_W + 12 - 16;
  localparam int DAMP_COEF = 2184;
  localparam int A_W       = STEP_W + RAMP2_W;

  // Weight divider: Q1.30 weight.
  localparam int W_BITS   = 30;
  localparam int WGT_W    = W_BITS + 1;
  localparam int DEN2_W   = 64;
  localparam int REM2_W   = DEN2_W + 1;
  localparam int WGT_LAT  = W_BITS + 2;

  localparam int LATE_DL  = WGT_LAT - 1;
  localparam int LATENCY  = RAMP_LAT + WGT_LAT + 6;

  typedef struct packed {
    logic        vld;
    logic        zone;
  } rwdz_ctl_t;

  typedef struct packed {
    logic [RADIUS_W-1:0]    r;
    logic [VALUE_WIDTH-1:0] dens;
    logic [VALUE_WIDTH-1:0] vaz;
    logic [VALUE_WIDTH-1:0] vrad;
    logic [VALUE_WIDTH-1:0] tdens;
    logic [VALUE_WIDTH-1:0] tvaz;
    logic [VALUE_WIDTH-1:0] tvrad;
  } cell_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] x_dens;
    logic [VALUE_WIDTH-1:0] x_vaz;
    logic [VALUE_WIDTH-1:0] x_vrad;
    logic [DIFF_W-1:0]      d_dens;
    logic [DIFF_W-1:0]      d_vaz;
    logic [DIFF_W-1:0]      d_vrad;
    logic                   pass;
  } late_t;

  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  function automatic logic [VALUE_WIDTH-1:0] sat_value(input logic signed [63:0] v);
    logic [VALUE_WIDTH-1:0] res;
    if (v > SAT_HI) begin
      res = SAT_HI[VALUE_WIDTH-1:0];
    end else if (v < SAT_LO) begin
      res = SAT_LO[VALUE_WIDTH-1:0];
    end else begin
      res = v[VALUE_WIDTH-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* design/rwdz_ramp_div.sv */
// Pipelined restoring divider for the zone ramp, one quotient bit per stage.
// Depends on rwdz_pkg.
`default_nettype none

module rwdz_ramp_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire rwdz_pkg::rwdz_ctl_t              ctl,
  input  wire logic signed [rwdz_pkg::POS_W-1:0] num,
  input  wire logic signed [rwdz_pkg::POS_W-1:0] den,
  output logic                                  out_valid,
  output logic [rwdz_pkg::RAMP_W-1:0]           ramp
);

  localparam logic [rwdz_pkg::RAMP_W-1:0] RampCap =
    rwdz_pkg::RAMP_W'(1) << (rwdz_pkg::RAMP_W - 1);

  logic                          vld  [rwdz_pkg::RAMP_STEPS+1];
  logic                          zone [rwdz_pkg::RAMP_STEPS+1];
  logic                          cap  [rwdz_pkg::RAMP_STEPS+1];
  logic [rwdz_pkg::RDIV_W-1:0]   rem  [rwdz_pkg::RAMP_STEPS+1];
  logic [rwdz_pkg::POS_W-2:0]    dv   [rwdz_pkg::RAMP_STEPS+1];
  logic [rwdz_pkg::RAMP_W-1:0]   quo  [rwdz_pkg::RAMP_STEPS+1];
  logic                          cap_in;

  // The ramp saturates when the zone is empty or the quotient reaches 128.0.
  assign cap_in = (den <= 0) ||
                  ($signed(rwdz_pkg::CAP_W'(num)) >= ($signed(rwdz_pkg::CAP_W'(den)) <<< 8));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= ctl.vld;
    end
    zone[0] <= ctl.zone;
    cap[0]  <= cap_in;
    rem[0]  <= rwdz_pkg::RDIV_W'({num[rwdz_pkg::POS_W-2:0], 16'b0});
    dv[0]   <= den[rwdz_pkg::POS_W-2:0];
    quo[0]  <= '0;
  end

  for (genvar i = 0; i < rwdz_pkg::RAMP_STEPS; i++) begin : g_step
    logic [rwdz_pkg::RDIV_W-1:0] dsh;
    logic                        ge;
    assign dsh = rwdz_pkg::RDIV_W'(dv[i]) << (rwdz_pkg::RAMP_W - 1 - i);
    assign ge  = rem[i] >= dsh;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      zone[i+1] <= zone[i];
      cap[i+1]  <= cap[i];
      dv[i+1]   <= dv[i];
      rem[i+1]  <= ge ? rem[i] - dsh : rem[i];
      quo[i+1]  <= quo[i] | (ge ? rwdz_pkg::RAMP_W'(1) << (rwdz_pkg::RAMP_W - 1 - i) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[rwdz_pkg::RAMP_STEPS];
    end
    if (!zone[rwdz_pkg::RAMP_STEPS]) begin
      ramp <= '0;
    end else if (cap[rwdz_pkg::RAMP_STEPS] || quo[rwdz_pkg::RAMP_STEPS][rwdz_pkg::RAMP_W-1]) begin
      ramp <= RampCap;
    end else begin
      ramp <= quo[rwdz_pkg::RAMP_STEPS];
    end
  end

endmodule

`default_nettype wire

/* design/rwdz_isqrt.sv */
// Pipelined digit-by-digit integer square root of radius * 2^16, one root bit per stage.
// Depends on rwdz_pkg.
`default_nettype none

module rwdz_isqrt (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire logic [rwdz_pkg::RADIUS_W-1:0]   radius,
  output logic                                 out_valid,
  output logic [rwdz_pkg::ROOT_W-1:0]          root
);

  logic                          vld [rwdz_pkg::ROOT_W+1];
  logic [rwdz_pkg::RADIUS_W-1:0] rad [rwdz_pkg::ROOT_W+1];
  logic [rwdz_pkg::SQ_REM_W-1:0] rem [rwdz_pkg::ROOT_W+1];
  logic [rwdz_pkg::ROOT_W-1:0]   rt  [rwdz_pkg::ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    rad[0] <= radius;
    rem[0] <= '0;
    rt[0]  <= '0;
  end

  for (genvar i = 0; i < rwdz_pkg::ROOT_W; i++) begin : g_step
    logic [rwdz_pkg::SQ_IN_W-1:0]  xin;
    logic [rwdz_pkg::SQ_REM_W-1:0] cur;
    logic [rwdz_pkg::SQ_REM_W-1:0] trial;
    logic                          ge;
    assign xin   = {1'b0, rad[i], 16'b0};
    assign cur   = {rem[i][rwdz_pkg::SQ_REM_W-3:0], xin[rwdz_pkg::SQ_IN_W-1-2*i -: 2]};
    assign trial = rwdz_pkg::SQ_REM_W'({rt[i], 2'b01});
    assign ge    = cur >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      rad[i+1] <= rad[i];
      rem[i+1] <= ge ? cur - trial : cur;
      rt[i+1]  <= {rt[i][rwdz_pkg::ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[rwdz_pkg::ROOT_W];
    end
    root <= rt[rwdz_pkg::ROOT_W];
  end

endmodule

`default_nettype wire

/* design/rwdz_weight_div.sv */
// Pipelined fractional divider for the relaxation weight a / (a + tau * 2^16), Q1.30.
// Depends on rwdz_pkg.
`default_nettype none

module rwdz_weight_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic [rwdz_pkg::A_W-1:0]     a,
  input  wire logic [rwdz_pkg::TAU_W-1:0]   tau,
  output logic                              out_valid,
  output logic [rwdz_pkg::WGT_W-1:0]        w
);

  logic                          vld  [rwdz_pkg::W_BITS+1];
  logic                          full [rwdz_pkg::W_BITS+1];
  logic [rwdz_pkg::DEN2_W-1:0]   dnm  [rwdz_pkg::W_BITS+1];
  logic [rwdz_pkg::REM2_W-1:0]   rem  [rwdz_pkg::W_BITS+1];
  logic [rwdz_pkg::W_BITS-1:0]   acc  [rwdz_pkg::W_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    // With no damping time the weight is exactly one, unless the step term is zero.
    full[0] <= (tau == '0) && (a != '0);
    dnm[0]  <= rwdz_pkg::DEN2_W'(a) + (rwdz_pkg::DEN2_W'(tau) << 16);
    rem[0]  <= rwdz_pkg::REM2_W'(a);
    acc[0]  <= '0;
  end

  for (genvar i = 0; i < rwdz_pkg::W_BITS; i++) begin : g_step
    logic [rwdz_pkg::REM2_W-1:0] sh;
    logic                        ge;
    assign sh = {rem[i][rwdz_pkg::REM2_W-2:0], 1'b0};
    assign ge = sh >= rwdz_pkg::REM2_W'(dnm[i]);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      full[i+1] <= full[i];
      dnm[i+1]  <= dnm[i];
      rem[i+1]  <= ge ? sh - rwdz_pkg::REM2_W'(dnm[i]) : sh;
      acc[i+1]  <= {acc[i][rwdz_pkg::W_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[rwdz_pkg::W_BITS];
    end
    if (full[rwdz_pkg::W_BITS]) begin
      w <= rwdz_pkg::WGT_W'(1) << rwdz_pkg::W_BITS;
    end else if (dnm[rwdz_pkg::W_BITS] == '0) begin
      // Both the step term and the damping time are zero: the weight is zero.
      w <= '0;
    end else begin
      w <= {1'b0, acc[rwdz_pkg::W_BITS]};
    end
  end

endmodule

`default_nettype wire

/* design/radial_wave_damping_zone.sv */
// Top level of the radial wave damping zone: config registers, zone test and relaxation.
// Depends on rwdz_pkg, rwdz_ramp_div, rwdz_isqrt, rwdz_weight_div and the defines header.
`default_nettype none
`include "radial_wave_damping_zone_defines.svh"

// The block relaxes one grid cell toward its reference state per item. It
// accepts an item in every clock cycle: busy is always low, and start alone
// launches a cell. Each result leaves on the cycle in which done is high,
// and results come out in start order. The receiver cannot hold results
// off, so nothing is buffered at the output and the pipeline never stalls.
// A cell passes through two dividers and a square root: the zone ramp
// divider and the radius square root run side by side for 26 stages, and
// the relaxation weight divider takes 32 more. Configuration is written
// through wr_en, wr_index and wr_data, one register per cycle; the zone
// edges are recomputed on the cycle after a write, so a cell started on
// the cycle after a write already sees the new setting.
module radial_wave_damping_zone (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    start,
  output logic                                         busy,
  input  wire logic                                    wr_en,
  input  wire logic [rwdz_pkg::CFG_IDX_W-1:0]          wr_index,
  input  wire logic [rwdz_pkg::VALUE_WIDTH-1:0]        wr_data,
  input  wire logic [rwdz_pkg::RADIUS_W-1:0]           cell_radius,
  input  wire logic signed [rwdz_pkg::VALUE_WIDTH-1:0] cell_density,
  input  wire logic signed [rwdz_pkg::VALUE_WIDTH-1:0] cell_vel_azimuthal,
  input  wire logic signed [rwdz_pkg::VALUE_WIDTH-1:0] cell_vel_radial,
  input  wire logic signed [rwdz_pkg::VALUE_WIDTH-1:0] ref_density,
  input  wire logic signed [rwdz_pkg::VALUE_WIDTH-1:0] ref_vel_azimuthal,
  input  wire logic signed [rwdz_pkg::VALUE_WIDTH-1:0] ref_vel_radial,
  output logic                                         done,
  output logic signed [rwdz_pkg::VALUE_WIDTH-1:0]      new_density,
  output logic signed [rwdz_pkg::VALUE_WIDTH-1:0]      new_vel_azimuthal,
  output logic signed [rwdz_pkg::VALUE_WIDTH-1:0]      new_vel_radial,
  output logic                                         in_zone
);

  localparam int VW = rwdz_pkg::VALUE_WIDTH;

  // Configuration registers.
  logic signed [VW-1:0]               y_min;
  logic signed [VW-1:0]               y_max;
  logic [rwdz_pkg::FRAC_W-1:0]        inner_fraction;
  logic [rwdz_pkg::FRAC_W-1:0]        outer_fraction;
  logic [rwdz_pkg::STEP_W-1:0]        time_step;
  logic signed [VW-1:0]               frame_rate_shift;

  // Zone edges derived from the configuration.
  logic signed [rwdz_pkg::SPAN_W-1:0]  span;
  logic signed [rwdz_pkg::OFS_P_W-1:0] ofs_in_p;
  logic signed [rwdz_pkg::OFS_P_W-1:0] ofs_out_p;
  logic signed [rwdz_pkg::POS_W-1:0]   ofs_in;
  logic signed [rwdz_pkg::POS_W-1:0]   ofs_out;
  logic signed [rwdz_pkg::POS_W-1:0]   yinf;
  logic signed [rwdz_pkg::POS_W-1:0]   ysup;

  // Input and zone test stages.
  rwdz_pkg::cell_t                     c0;
  logic                                v0;
  rwdz_pkg::cell_t                     c1;
  rwdz_pkg::rwdz_ctl_t                 ctl1;
  logic signed [rwdz_pkg::POS_W-1:0]   num1;
  logic signed [rwdz_pkg::POS_W-1:0]   den1;
  logic signed [rwdz_pkg::POS_W-1:0]   r_pos;
  logic                                above;
  logic                                below;

  // Payload riding beside the ramp divider and square root.
  rwdz_pkg::cell_t                     cdl [rwdz_pkg::RAMP_LAT];
  rwdz_pkg::cell_t                     cd;
  logic                                ramp_vld;
  logic [rwdz_pkg::RAMP_W-1:0]         ramp;
  logic                                root_vld;
  logic [rwdz_pkg::ROOT_W-1:0]         root;

  // Stage after the dividers: ramp squared, first tau product, frame correction.
  logic                                v_m;
  logic [rwdz_pkg::RAMP2_W-1:0]        ramp2_m;
  logic [rwdz_pkg::TAU1_W-1:0]         tau1_m;
  logic signed [63:0]                  frs_m;
  logic [47:0]                         rsq;
  logic [rwdz_pkg::RADIUS_W+rwdz_pkg::ROOT_W-1:0] rroot;
  logic signed [rwdz_pkg::DIFF_W-1:0]  dden_m;
  logic signed [rwdz_pkg::DIFF_W-1:0]  dvrad_m;
  logic [VW-1:0]                       xd_m;
  logic [VW-1:0]                       xa_m;
  logic [VW-1:0]                       xr_m;
  logic signed [VW-1:0]                tvaz_m;

  // Stage feeding the weight divider.
  logic                                v_n;
  logic [rwdz_pkg::A_W-1:0]            a_n;
  logic [rwdz_pkg::TAU_W-1:0]          tau_n;
  logic [rwdz_pkg::TAU1_W+12-1:0]      taup;
  logic signed [VW-1:0]                tvadj_n;
  logic                                pass_n;
  logic signed [rwdz_pkg::DIFF_W-1:0]  dden_n;
  logic signed [rwdz_pkg::DIFF_W-1:0]  dvrad_n;
  logic [VW-1:0]                       xd_n;
  logic [VW-1:0]                       xa_n;
  logic [VW-1:0]                       xr_n;

  // Payload riding beside the weight divider.
  rwdz_pkg::late_t                     late_p;
  rwdz_pkg::late_t                     ldl [rwdz_pkg::LATE_DL];
  rwdz_pkg::late_t                     ld;
  logic                                w_vld;
  logic [rwdz_pkg::WGT_W-1:0]          w;

  // Products of the differences and the weight.
  logic                                v_q;
  logic signed [63:0]                  pd_q;
  logic signed [63:0]                  pa_q;
  logic signed [63:0]                  pr_q;
  rwdz_pkg::late_t                     lq;

  assign busy = 1'b0;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      y_min            <= '0;
      y_max            <= VW'(65536);
      inner_fraction   <= '0;
      outer_fraction   <= '0;
      time_step        <= '0;
      frame_rate_shift <= '0;
    end else if (wr_en) begin
      case (rwdz_pkg::cfg_reg_t'(wr_index))
        rwdz_pkg::REG_Y_MIN:            y_min            <= wr_data;
        rwdz_pkg::REG_Y_MAX:            y_max            <= wr_data;
        rwdz_pkg::REG_INNER_FRACTION:   inner_fraction   <= wr_data[rwdz_pkg::FRAC_W-1:0];
        rwdz_pkg::REG_OUTER_FRACTION:   outer_fraction   <= wr_data[rwdz_pkg::FRAC_W-1:0];
        rwdz_pkg::REG_TIME_STEP:        time_step        <= wr_data[rwdz_pkg::STEP_W-1:0];
        rwdz_pkg::REG_FRAME_RATE_SHIFT: frame_rate_shift <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // Zone widths are span * fraction, floored to Q16.16. They double as the
  // ramp denominators: y_max - Y_sup and Y_inf - y_min.
  assign span      = rwdz_pkg::SPAN_W'(y_max) - rwdz_pkg::SPAN_W'(y_min);
  assign ofs_in_p  = rwdz_pkg::OFS_P_W'(span) * $signed({1'b0, inner_fraction});
  assign ofs_out_p = rwdz_pkg::OFS_P_W'(span) * $signed({1'b0, outer_fraction});

  always_ff @(posedge clk) begin
    ofs_in  <= rwdz_pkg::POS_W'(ofs_in_p >>> 16);
    ofs_out <= rwdz_pkg::POS_W'(ofs_out_p >>> 16);
    yinf    <= rwdz_pkg::POS_W'(y_min) + rwdz_pkg::POS_W'(ofs_in_p >>> 16);
    ysup    <= rwdz_pkg::POS_W'(y_max) - rwdz_pkg::POS_W'(ofs_out_p >>> 16);
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    c0.r     <= cell_radius;
    c0.dens  <= cell_density;
    c0.vaz   <= cell_vel_azimuthal;
    c0.vrad  <= cell_vel_radial;
    c0.tdens <= ref_density;
    c0.tvaz  <= ref_vel_azimuthal;
    c0.tvrad <= ref_vel_radial;
  end

  // Zone test. When the cell lies in both zones the inner zone wins.
  assign r_pos = $signed(rwdz_pkg::POS_W'(c0.r));
  assign above = r_pos > ysup;
  assign below = r_pos < yinf;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.vld <= 1'b0;
    end else begin
      ctl1.vld <= v0;
    end
    ctl1.zone <= above || below;
    num1      <= below ? yinf - r_pos : r_pos - ysup;
    den1      <= below ? ofs_in : ofs_out;
    c1        <= c0;
  end

  rwdz_ramp_div u_ramp_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl1),
    .num       (num1),
    .den       (den1),
    .out_valid (ramp_vld),
    .ramp      (ramp)
  );

  rwdz_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ctl1.vld),
    .radius    (c1.r),
    .out_valid (root_vld),
    .root      (root)
  );

  always_ff @(posedge clk) begin
    cdl[0] <= c1;
    for (int j = 1; j < rwdz_pkg::RAMP_LAT; j++) begin
      cdl[j] <= cdl[j-1];
    end
  end

  assign cd    = cdl[rwdz_pkg::RAMP_LAT-1];
  assign rsq   = 48'(ramp) * 48'(ramp);
  assign rroot = (rwdz_pkg::RADIUS_W + rwdz_pkg::ROOT_W)'(cd.r) *
                 (rwdz_pkg::RADIUS_W + rwdz_pkg::ROOT_W)'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m <= 1'b0;
    end else begin
      v_m <= ramp_vld;
    end
    ramp2_m <= rsq[16 +: rwdz_pkg::RAMP2_W];
    tau1_m  <= rroot[16 +: rwdz_pkg::TAU1_W];
    frs_m   <= 64'(frame_rate_shift) * 64'($signed({1'b0, cd.r}));
    dden_m  <= rwdz_pkg::DIFF_W'($signed(cd.tdens)) - rwdz_pkg::DIFF_W'($signed(cd.dens));
    dvrad_m <= rwdz_pkg::DIFF_W'($signed(cd.tvrad)) - rwdz_pkg::DIFF_W'($signed(cd.vrad));
    xd_m    <= cd.dens;
    xa_m    <= cd.vaz;
    xr_m    <= cd.vrad;
    tvaz_m  <= cd.tvaz;
  end

  // tau = 0.03333 * r^1.5, second product.
  assign taup = (rwdz_pkg::TAU1_W + 12)'(tau1_m) * (rwdz_pkg::TAU1_W + 12)'(rwdz_pkg::DAMP_COEF);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_n <= 1'b0;
    end else begin
      v_n <= v_m;
    end
    a_n     <= rwdz_pkg::A_W'(time_step) * rwdz_pkg::A_W'(ramp2_m);
    tau_n   <= taup[16 +: rwdz_pkg::TAU_W];
    tvadj_n <= rwdz_pkg::sat_value(64'(tvaz_m) - (frs_m >>> 16));
    pass_n  <= ramp2_m == '0;
    dden_n  <= dden_m;
    dvrad_n <= dvrad_m;
    xd_n    <= xd_m;
    xa_n    <= xa_m;
    xr_n    <= xr_m;
  end

  rwdz_weight_div u_weight_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_n),
    .a         (a_n),
    .tau       (tau_n),
    .out_valid (w_vld),
    .w         (w)
  );

  always_ff @(posedge clk) begin
    late_p.x_dens <= xd_n;
    late_p.x_vaz  <= xa_n;
    late_p.x_vrad <= xr_n;
    late_p.d_dens <= dden_n;
    late_p.d_vaz  <= rwdz_pkg::DIFF_W'(tvadj_n) - rwdz_pkg::DIFF_W'($signed(xa_n));
    late_p.d_vrad <= dvrad_n;
    late_p.pass   <= pass_n;
    ldl[0]        <= late_p;
    for (int j = 1; j < rwdz_pkg::LATE_DL; j++) begin
      ldl[j] <= ldl[j-1];
    end
  end

  assign ld = ldl[rwdz_pkg::LATE_DL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= 1'b0;
    end else begin
      v_q <= w_vld;
    end
    pd_q <= 64'($signed(ld.d_dens)) * 64'($signed({1'b0, w}));
    pa_q <= 64'($signed(ld.d_vaz))  * 64'($signed({1'b0, w}));
    pr_q <= 64'($signed(ld.d_vrad)) * 64'($signed({1'b0, w}));
    lq   <= ld;
  end

  // Relaxed value is x + floor(d * w / 2^30), saturated; cells that were not
  // relaxed leave unchanged.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_q;
    end
    in_zone <= !lq.pass;
    if (lq.pass) begin
      new_density       <= lq.x_dens;
      new_vel_azimuthal <= lq.x_vaz;
      new_vel_radial    <= lq.x_vrad;
    end else begin
      new_density       <= rwdz_pkg::sat_value(64'($signed(lq.x_dens)) + (pd_q >>> rwdz_pkg::W_BITS));
      new_vel_azimuthal <= rwdz_pkg::sat_value(64'($signed(lq.x_vaz)) + (pa_q >>> rwdz_pkg::W_BITS));
      new_vel_radial    <= rwdz_pkg::sat_value(64'($signed(lq.x_vrad)) + (pr_q >>> rwdz_pkg::W_BITS));
    end
  end

  `RWDZ_ASSERT_DELAY(a_result_latency, clk, rst, start && !busy, rwdz_pkg::LATENCY, done)
  `RWDZ_ASSERT_IMPLIES(a_units_aligned, clk, rst, 1'b1, ramp_vld == root_vld)
  `RWDZ_ASSERT_IMPLIES(a_pass_radial, clk, rst, done && !in_zone, new_vel_radial == $past(cell_vel_radial, rwdz_pkg::LATENCY))
  `RWDZ_ASSERT_IMPLIES(a_pass_density, clk, rst, done && !in_zone, new_density == $past(cell_density, rwdz_pkg::LATENCY))

endmodule

`default_nettype wire

/* tb/radial_wave_damping_zone_test.sv */
// Self-checking testbench for the radial wave damping zone.
// Depends on rwdz_pkg and radial_wave_damping_zone. It predicts every relaxed cell
// and compares the block's results against those predictions in order.
`default_nettype none

// Holds the register settings, computes the relaxed cell for each accepted
// item and keeps the cells in flight until the block returns them.
class damping_scoreboard;
  typedef struct {
    logic [31:0] dens;
    logic [31:0] vaz;
    logic [31:0] vrad;
    logic        zone;
  } relaxed_cell_t;

  relaxed_cell_t pending_cells[$];
  longint y_lo, y_hi, frame_shift;
  longint unsigned frac_in, frac_out, dt;
  int mismatches;

  function new();
    y_lo = 0;
    y_hi = 65536;
    frac_in = 0;
    frac_out = 0;
    dt = 0;
    frame_shift = 0;
    mismatches = 0;
  endfunction

  function void write_reg(input rwdz_pkg::cfg_reg_t idx, input logic [31:0] val);
    case (idx)
      rwdz_pkg::REG_Y_MIN:            y_lo = longint'($signed(val));
      rwdz_pkg::REG_Y_MAX:            y_hi = longint'($signed(val));
      rwdz_pkg::REG_INNER_FRACTION:   frac_in = val[16:0];
      rwdz_pkg::REG_OUTER_FRACTION:   frac_out = val[16:0];
      rwdz_pkg::REG_TIME_STEP:        dt = val[30:0];
      rwdz_pkg::REG_FRAME_RATE_SHIFT: frame_shift = longint'($signed(val));
      default: ;
    endcase
  endfunction

  static function longint clamp32(input longint v);
    longint res;
    if (v > 64'sd2147483647) begin
      res = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      res = -64'sd2147483648;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Bitwise integer square root, floor.
  static function longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  static function longint pull(input longint x, input longint tgt, input longint w);
    return clamp32(x + (((tgt - x) * w) >>> 30));
  endfunction

  function void note_cell(input rwdz_pkg::cell_t c);
    longint r, span, yinf, ysup, num, den, ramp, ramp2, dens, vaz, vrad, tvaz, w;
    longint unsigned tau, a, denom;
    logic [127:0] wide;
    bit zone;
    relaxed_cell_t e;
    r = c.r;
    dens = longint'($signed(c.dens));
    vaz = longint'($signed(c.vaz));
    vrad = longint'($signed(c.vrad));
    span = y_hi - y_lo;
    yinf = y_lo + ((span * longint'(frac_in)) >>> 16);
    ysup = y_hi - ((span * longint'(frac_out)) >>> 16);
    zone = 0;
    ramp = 0;
    num = 0;
    den = 0;
    if (r > ysup) begin
      num = r - ysup;
      den = y_hi - ysup;
      zone = 1;
    end
    // The inner zone takes precedence when both zones overlap.
    if (r < yinf) begin
      num = yinf - r;
      den = yinf - y_lo;
      zone = 1;
    end
    if (zone) begin
      if (den <= 0) begin
        ramp = 64'sd128 <<< 16;
      end else begin
        ramp = (num <<< 16) / den;
        if (ramp > (64'sd128 <<< 16)) ramp = 64'sd128 <<< 16;
      end
    end
    ramp2 = (ramp * ramp) >>> 16;
    e.dens = dens[31:0];
    e.vaz = vaz[31:0];
    e.vrad = vrad[31:0];
    e.zone = 0;
    if (ramp2 > 0) begin
      tau = (longint'(r) * int_sqrt(longint'(r) << 16)) >> 16;
      tau = (tau * 2184) >> 16;
      a = dt * longint'(ramp2);
      denom = a + (tau << 16);
      if (a == 0) begin
        w = 0;
      end else if (a >= denom) begin
        w = 64'sd1 <<< 30;
      end else begin
        wide = ({64'd0, a} << 30) / {64'd0, denom};
        w = longint'(wide[63:0]);
      end
      tvaz = clamp32(longint'($signed(c.tvaz)) - ((frame_shift * r) >>> 16));
      e.dens = pull(dens, longint'($signed(c.tdens)), w);
      e.vaz = pull(vaz, tvaz, w);
      e.vrad = pull(vrad, longint'($signed(c.tvrad)), w);
      e.zone = 1;
    end
    pending_cells.push_back(e);
  endfunction

  function void check_cell(input logic [31:0] dens, input logic [31:0] vaz,
                           input logic [31:0] vrad, input logic zone);
    relaxed_cell_t e;
    if (pending_cells.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: result with no item outstanding");
      return;
    end
    e = pending_cells.pop_front();
    if (e.dens !== dens || e.vaz !== vaz || e.vrad !== vrad || e.zone !== zone) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: expected dens=%h vaz=%h vrad=%h zone=%b", e.dens, e.vaz, e.vrad,
                 e.zone);
        $display("       got      dens=%h vaz=%h vrad=%h zone=%b", dens, vaz, vrad, zone);
      end
    end
  endfunction
endclass

module radial_wave_damping_zone_test;

  localparam int TOTAL_ITEMS = 1450;
  localparam int SETTINGS_COUNT = 12;

  logic clk, rst, start, busy, wr_en, done, in_zone;
  logic [rwdz_pkg::CFG_IDX_W-1:0] wr_index;
  logic [31:0] wr_data;
  logic [rwdz_pkg::RADIUS_W-1:0] cell_radius;
  logic signed [31:0] cell_density, cell_vel_azimuthal, cell_vel_radial;
  logic signed [31:0] ref_density, ref_vel_azimuthal, ref_vel_radial;
  logic signed [31:0] new_density, new_vel_azimuthal, new_vel_radial;

  damping_scoreboard relax_book;
  int items_sent;
  int sender_idle_pct;

  radial_wave_damping_zone dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .cell_radius(cell_radius), .cell_density(cell_density),
    .cell_vel_azimuthal(cell_vel_azimuthal), .cell_vel_radial(cell_vel_radial),
    .ref_density(ref_density), .ref_vel_azimuthal(ref_vel_azimuthal),
    .ref_vel_radial(ref_vel_radial), .done(done), .new_density(new_density),
    .new_vel_azimuthal(new_vel_azimuthal), .new_vel_radial(new_vel_radial),
    .in_zone(in_zone)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Results cannot be held off, so every done cycle is checked on the edge
  // that ends it; outputs are read before that edge's updates land.
  always @(posedge clk) begin
    if (!rst && done) begin
      relax_book.check_cell(new_density, new_vel_azimuthal, new_vel_radial, in_zone);
    end
  end

  // Generous bound: well above the slowest legal run with every idle gap.
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  // A value that is fully random, small, medium or one of two 32-bit extremes, so
  // that both the saturating extremes and ordinary relaxations are common.
  function automatic logic [31:0] any_value();
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(32'hFFFF) - 32'h8000;
      2: v = ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: v = $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
    endcase
    return v;
  endfunction

  // Waits until the block has returned every outstanding cell, then writes
  // one register. Items always produce a result, so nothing else is in flight.
  task automatic set_reg(input rwdz_pkg::cfg_reg_t idx, input logic [31:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (relax_book.pending_cells.size() != 0) @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    relax_book.write_reg(idx, val);
    wr_en <= 1'b0;
  endtask

  task automatic apply_setting(input logic [31:0] lo, input logic [31:0] hi,
                               input logic [16:0] fin, input logic [16:0] fout,
                               input logic [30:0] step, input logic [31:0] shift);
    set_reg(rwdz_pkg::REG_Y_MIN, lo);
    set_reg(rwdz_pkg::REG_Y_MAX, hi);
    set_reg(rwdz_pkg::REG_INNER_FRACTION, {15'd0, fin});
    set_reg(rwdz_pkg::REG_OUTER_FRACTION, {15'd0, fout});
    set_reg(rwdz_pkg::REG_TIME_STEP, {1'b0, step});
    set_reg(rwdz_pkg::REG_FRAME_RATE_SHIFT, shift);
  endtask

  // Presents one cell and holds it until accepted. start stays high after
  // acceptance; a following idle gap or the next cell decides its next value.
  task automatic send_cell(input rwdz_pkg::cell_t c);
    start <= 1'b1;
    cell_radius <= c.r;
    cell_density <= c.dens;
    cell_vel_azimuthal <= c.vaz;
    cell_vel_radial <= c.vrad;
    ref_density <= c.tdens;
    ref_vel_azimuthal <= c.tvaz;
    ref_vel_radial <= c.tvrad;
    do @(posedge clk); while (busy);
    relax_book.note_cell(c);
    items_sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic rwdz_pkg::cell_t make_cell(input logic [30:0] r);
    rwdz_pkg::cell_t c;
    c.r = r;
    c.dens = any_value();
    c.vaz = any_value();
    c.vrad = any_value();
    c.tdens = any_value();
    c.tvaz = any_value();
    c.tvrad = any_value();
    return c;
  endfunction

  // Radii are mostly drawn around the configured domain so both zones and
  // the middle band are hit; the rest cover the whole radius range.
  function automatic logic [30:0] pick_radius();
    longint lo, hi, span, v;
    lo = relax_book.y_lo;
    hi = relax_book.y_hi;
    span = (hi > lo) ? hi - lo : 64'd65536;
    if ($urandom_range(4) == 0) begin
      v = $urandom & 32'h7FFF_FFFF;
    end else begin
      v = lo - span / 8 + longint'($urandom_range(1000)) * (span + span / 4) / 1000;
    end
    if (v < 0) v = $urandom_range(3);
    if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF - $urandom_range(3);
    return v[30:0];
  endfunction

  initial begin
    rwdz_pkg::cell_t c;
    int per_setting;
    relax_book = new();
    items_sent = 0;
    sender_idle_pct = 7;
    rst = 1'b1;
    start = 1'b0;
    wr_en = 1'b0;
    wr_index = rwdz_pkg::REG_Y_MIN;
    wr_data = '0;
    cell_radius = '0;
    cell_density = '0;
    cell_vel_azimuthal = '0;
    cell_vel_radial = '0;
    ref_density = '0;
    ref_vel_azimuthal = '0;
    ref_vel_radial = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: zero-width zones and a zero time step, so both cells come out unchanged.
    send_cell(make_cell(31'd0));
    send_cell(make_cell(31'h7FFF_FFFF));

    // Domain 1.0 .. 5.0 with quarter-width zones, a real time step and a
    // frame shift: inner, middle and outer cells, the domain edges themselves.
    apply_setting(32'h0001_0000, 32'h0005_0000, 17'h4000, 17'h4000, 31'h0000_1000,
                  32'h0000_8000);
    send_cell(make_cell(31'h0001_0000));
    send_cell(make_cell(31'h0001_8000));
    send_cell(make_cell(31'h0003_0000));
    send_cell(make_cell(31'h0004_c000));
    send_cell(make_cell(31'h0005_0000));
    send_cell(make_cell(31'h0006_0000));
    // Zone edge itself gives a zero ramp: pass through with in_zone low.
    send_cell(make_cell(31'h0002_0000));
    // Radius zero gives a zero damping time, so the target comes out whole.
    send_cell(make_cell(31'd0));
    c = make_cell(31'h0001_0000);
    c.dens = 32'h8000_0000;
    c.tdens = 32'h7FFF_FFFF;
    c.vaz = 32'h7FFF_FFFF;
    c.tvaz = 32'h8000_0000;
    send_cell(c);

    // Zero time step with zero radius: weight zero but the cell is in a zone.
    set_reg(rwdz_pkg::REG_TIME_STEP, 32'd0);
    send_cell(make_cell(31'd0));
    send_cell(make_cell(31'h0001_4000));

    // Full fractions over an inverted domain: the zone widths are negative and
    // no radius falls in a zone. Then the inner zone covers the whole domain.
    apply_setting(32'h7FFF_FFFF, 32'h8000_0000, 17'h10000, 17'h10000, 31'h7FFF_FFFF,
                  32'h7FFF_FFFF);
    send_cell(make_cell(31'd0));
    send_cell(make_cell(31'h7FFF_FFFF));
    send_cell(make_cell(31'h4000_0000));
    apply_setting(32'h8000_0000, 32'h7FFF_FFFF, 17'h10000, 17'd0, 31'h0000_0001,
                  32'h8000_0000);
    send_cell(make_cell(31'd0));
    send_cell(make_cell(31'h7FFF_FFFF));
    send_cell(make_cell(31'h0000_0001));

    // Random phases, each under a fresh setting; the idle pattern of the
    // sender changes over the run.
    per_setting = (TOTAL_ITEMS - items_sent) / SETTINGS_COUNT;
    for (int s = 0; s < SETTINGS_COUNT; s++) begin
      if (s == SETTINGS_COUNT / 3) sender_idle_pct = 58;
      if (s == 2 * SETTINGS_COUNT / 3) sender_idle_pct = 0;
      case (s % 4)
        0: apply_setting($urandom_range(32'h0010_0000), 32'h0010_0000 +
                         $urandom_range(32'h0100_0000), $urandom_range(17'h10000),
                         $urandom_range(17'h10000), $urandom, any_value());
        1: apply_setting($urandom_range(32'h0000_4000), 32'h0004_0000 +
                         $urandom_range(32'h0008_0000), $urandom_range(17'h8000),
                         $urandom_range(17'h8000), $urandom_range(32'h0004_0000),
                         any_value());
        2: apply_setting($urandom, $urandom, $urandom_range(17'h10000),
                         $urandom_range(17'h10000), $urandom, $urandom);
        default: apply_setting($urandom_range(32'h1000_0000), 32'h4000_0000 +
                               $urandom_range(32'h3FFF_FFFF),
                               ($urandom_range(1)) ? 17'h10000 : 17'd0,
                               ($urandom_range(1)) ? 17'h10000 : $urandom_range(17'h10000),
                               ($urandom_range(3) == 0) ? 31'd0 : $urandom,
                               any_value());
      endcase
      for (int k = 0; k < per_setting; k++) begin
        send_cell(make_cell(pick_radius()));
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (relax_book.pending_cells.size() != 0) @(posedge clk);
    repeat (rwdz_pkg::LATENCY + 8) @(posedge clk);
    if (relax_book.mismatches == 0 && relax_book.pending_cells.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
